// ===== rtl/core/gap_pkg.sv =====
// Package for the gimbal aim point block: field widths, register codes and
// the control group that travels down the pipeline. No dependencies.
package gap_pkg;

   localparam int BOX_W   = 16;
   localparam int ZOOM_W  = 12;
   localparam int FRAME_W = 13;
   localparam int AIM_W   = 18;

   localparam int AIM_MAX = 131071;
   localparam int AIM_MIN = -131072;

   localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
   localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic valid;
      logic neg_x;
      logic neg_y;
   } gap_ctl_type;

endpackage

// ===== rtl/core/gap_band.sv =====
// Front stages of the aim point pipeline: band products, band selection of
// the offsets and sign/magnitude split before division. Uses gap_pkg.
module gap_band import gap_pkg::*; #(
   parameter int COORD_FRAC_BITS = 4,
   parameter int ZOOM_FRAC_BITS  = 8,
   localparam int WQ_W  = FRAME_W + COORD_FRAC_BITS,
   localparam int S_W   = (WQ_W + 8 > 25) ? WQ_W + 8 : 25,
   localparam int ZQ_W  = (ZOOM_W > ZOOM_FRAC_BITS + 1) ? ZOOM_W : ZOOM_FRAC_BITS + 1,
   localparam int DEN_W = ZQ_W + 4,
   localparam int NUM_W = S_W - 1 + ZOOM_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              target_valid,
   input  logic [BOX_W-1:0]  box_x,
   input  logic [BOX_W-1:0]  box_y,
   input  logic [BOX_W-1:0]  box_width,
   input  logic [BOX_W-1:0]  box_height,
   input  logic [ZOOM_W-1:0] zoom,
   input  logic [WQ_W-1:0]   wq,
   input  logic [WQ_W-1:0]   hq,
   output gap_ctl_type       out_ctl,
   output logic [NUM_W-1:0]  out_num_x,
   output logic [NUM_W-1:0]  out_num_y,
   output logic [DEN_W-1:0]  out_den
);

   localparam logic signed [S_W-1:0] K2   = S_W'(2);
   localparam logic signed [S_W-1:0] K5   = S_W'(5);
   localparam logic signed [S_W-1:0] K6   = S_W'(6);
   localparam logic signed [S_W-1:0] K8   = S_W'(8);
   localparam logic signed [S_W-1:0] K10  = S_W'(10);
   localparam logic signed [S_W-1:0] K15  = S_W'(15);
   localparam logic signed [S_W-1:0] K20  = S_W'(20);
   localparam logic signed [S_W-1:0] K30  = S_W'(30);
   localparam logic signed [S_W-1:0] K70  = S_W'(70);
   localparam logic signed [S_W-1:0] K85  = S_W'(85);
   localparam logic signed [S_W-1:0] K100 = S_W'(100);
   localparam logic [ZQ_W-1:0]  ZQ_ONE = {{(ZQ_W-1){1'b0}}, 1'b1} << ZOOM_FRAC_BITS;
   localparam logic [DEN_W-1:0] D10    = DEN_W'(10);

   logic signed [S_W-1:0] xs, ys, ws, hs, wqs, hqs;
   logic [ZQ_W-1:0] zq;

   logic va_ff, va_in, tv_ff;
   logic signed [S_W-1:0] x100_ff, wq15_ff, wq85_ff, wq30_ff, wq70_ff;
   logic signed [S_W-1:0] nl_ff, nr_ff, nc_ff, wq5_ff;
   logic signed [S_W-1:0] ty_ff, hq6_ff, mt_ff, mb_ff;
   logic [DEN_W-1:0] den_a_ff;

   logic vb_ff;
   logic signed [S_W-1:0] n_ff, n_in, m_ff, m_in;
   logic [DEN_W-1:0] den_b_ff;

   gap_ctl_type ctl_ff, ctl_in;
   logic [S_W-1:0] mag_x, mag_y;
   logic [NUM_W-1:0] num_x_ff, num_y_ff;
   logic [DEN_W-1:0] den_c_ff;

   always_comb begin
      xs  = $signed({{(S_W-BOX_W){1'b0}}, box_x});
      ys  = $signed({{(S_W-BOX_W){1'b0}}, box_y});
      ws  = $signed({{(S_W-BOX_W){1'b0}}, box_width});
      hs  = $signed({{(S_W-BOX_W){1'b0}}, box_height});
      wqs = $signed({{(S_W-WQ_W){1'b0}}, wq});
      hqs = $signed({{(S_W-WQ_W){1'b0}}, hq});
      zq  = {{(ZQ_W-ZOOM_W){1'b0}}, zoom};
      if (zq < ZQ_ONE) begin
         zq = ZQ_ONE;
      end
      va_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
      end
   end

   always_ff @(posedge clock) begin
      tv_ff    <= target_valid;
      x100_ff  <= xs * K100;
      wq15_ff  <= wqs * K15;
      wq85_ff  <= wqs * K85;
      wq30_ff  <= wqs * K30;
      wq70_ff  <= wqs * K70;
      nl_ff    <= xs * K10 - ws * K5 - wqs * K5;
      nr_ff    <= xs * K10 + ws * K5 - wqs * K5;
      nc_ff    <= xs * K10 - wqs * K5;
      wq5_ff   <= wqs * K5;
      ty_ff    <= (ys * K2 - hs) * K10;
      hq6_ff   <= hqs * K6;
      mt_ff    <= ys * K20 - hs * K5 - hqs * K8;
      mb_ff    <= ys * K10 - hs - hqs * K5;
      den_a_ff <= {{(DEN_W-ZQ_W){1'b0}}, zq} * D10;
   end

   always_comb begin
      if (x100_ff <= wq15_ff) begin
         n_in = -wq5_ff;
      end else if (x100_ff >= wq85_ff) begin
         n_in = wq5_ff;
      end else if (x100_ff <= wq30_ff) begin
         n_in = nl_ff;
      end else if (x100_ff >= wq70_ff) begin
         n_in = nr_ff;
      end else begin
         n_in = nc_ff;
      end
      if (ty_ff < hq6_ff) begin
         m_in = mt_ff;
      end else begin
         m_in = mb_ff;
      end
      if (!tv_ff) begin
         n_in = '0;
         m_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      m_ff     <= m_in;
      den_b_ff <= den_a_ff;
   end

   always_comb begin
      ctl_in.valid = vb_ff;
      ctl_in.neg_x = n_ff[S_W-1];
      ctl_in.neg_y = m_ff[S_W-1];
      mag_x = ctl_in.neg_x ? $unsigned(-n_ff) : $unsigned(n_ff);
      mag_y = ctl_in.neg_y ? $unsigned(-m_ff) : $unsigned(m_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      num_x_ff <= {mag_x[S_W-2:0], {ZOOM_FRAC_BITS{1'b0}}};
      num_y_ff <= {mag_y[S_W-2:0], {ZOOM_FRAC_BITS{1'b0}}};
      den_c_ff <= den_b_ff;
   end

   assign out_ctl   = ctl_ff;
   assign out_num_x = num_x_ff;
   assign out_num_y = num_y_ff;
   assign out_den   = den_c_ff;

endmodule

// ===== rtl/core/gap_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes that
// share one divisor. Uses gap_pkg for the control group.
module gap_div import gap_pkg::*; #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  gap_ctl_type      in_ctl,
   input  logic [NUM_W-1:0] in_num_x,
   input  logic [NUM_W-1:0] in_num_y,
   input  logic [DEN_W-1:0] in_den,
   output gap_ctl_type      out_ctl,
   output logic [NUM_W-1:0] out_quo_x,
   output logic [NUM_W-1:0] out_quo_y
);

   logic [DEN_W-1:0] rem_x_st [NUM_W+1];
   logic [DEN_W-1:0] rem_y_st [NUM_W+1];
   logic [NUM_W-1:0] dq_x_st  [NUM_W+1];
   logic [NUM_W-1:0] dq_y_st  [NUM_W+1];
   logic [DEN_W-1:0] den_st   [NUM_W+1];
   gap_ctl_type      ctl_st   [NUM_W+1];

   logic [DEN_W-1:0] rem_x_ff [NUM_W];
   logic [DEN_W-1:0] rem_y_ff [NUM_W];
   logic [NUM_W-1:0] dq_x_ff  [NUM_W];
   logic [NUM_W-1:0] dq_y_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff   [NUM_W];
   gap_ctl_type      ctl_ff   [NUM_W];

   assign rem_x_st[0] = '0;
   assign rem_y_st[0] = '0;
   assign dq_x_st[0]  = in_num_x;
   assign dq_y_st[0]  = in_num_y;
   assign den_st[0]   = in_den;
   assign ctl_st[0]   = in_ctl;

   for (genvar k = 0; k < NUM_W; k++) begin : g_step
      logic [DEN_W:0] trial_x, trial_y, diff_x, diff_y;
      logic ge_x, ge_y;
      logic [DEN_W-1:0] rem_x_in, rem_y_in;
      logic [NUM_W-1:0] dq_x_in, dq_y_in;

      always_comb begin
         trial_x = {rem_x_st[k], dq_x_st[k][NUM_W-1]};
         trial_y = {rem_y_st[k], dq_y_st[k][NUM_W-1]};
         diff_x  = trial_x - {1'b0, den_st[k]};
         diff_y  = trial_y - {1'b0, den_st[k]};
         ge_x    = trial_x >= {1'b0, den_st[k]};
         ge_y    = trial_y >= {1'b0, den_st[k]};
         rem_x_in = ge_x ? diff_x[DEN_W-1:0] : trial_x[DEN_W-1:0];
         rem_y_in = ge_y ? diff_y[DEN_W-1:0] : trial_y[DEN_W-1:0];
         dq_x_in = {dq_x_st[k][NUM_W-2:0], ge_x};
         dq_y_in = {dq_y_st[k][NUM_W-2:0], ge_y};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else begin
            ctl_ff[k] <= ctl_st[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_x_ff[k] <= rem_x_in;
         rem_y_ff[k] <= rem_y_in;
         dq_x_ff[k]  <= dq_x_in;
         dq_y_ff[k]  <= dq_y_in;
         den_ff[k]   <= den_st[k];
      end

      assign rem_x_st[k+1] = rem_x_ff[k];
      assign rem_y_st[k+1] = rem_y_ff[k];
      assign dq_x_st[k+1]  = dq_x_ff[k];
      assign dq_y_st[k+1]  = dq_y_ff[k];
      assign den_st[k+1]   = den_ff[k];
      assign ctl_st[k+1]   = ctl_ff[k];
   end

   assign out_ctl   = ctl_st[NUM_W];
   assign out_quo_x = dq_x_st[NUM_W];
   assign out_quo_y = dq_y_st[NUM_W];

endmodule

// ===== rtl/core/gimbal_aim_point_from_box.sv =====
// Top level of the gimbal aim point block: APB registers, front stages,
// divider and the saturating output stage. Uses gap_pkg, gap_band, gap_div.
// The divider divides by ten times the zoom, one quotient bit per stage, between
// the front stages and the output register; one transfer per cycle.
// busy stays low. Synchronous reset clears all valid bits and loads the frame
// size registers with 1920 by 1080; the receiver cannot stall.
module gimbal_aim_point_from_box import gap_pkg::*; #(
   parameter int COORD_FRAC_BITS = 4,
   parameter int ZOOM_FRAC_BITS  = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_target_valid,
   input  logic [BOX_W-1:0]        req_box_x,
   input  logic [BOX_W-1:0]        req_box_y,
   input  logic [BOX_W-1:0]        req_box_width,
   input  logic [BOX_W-1:0]        req_box_height,
   input  logic [ZOOM_W-1:0]       req_zoom,
   output logic                    rsp_valid,
   output logic signed [AIM_W-1:0] rsp_aim_x,
   output logic signed [AIM_W-1:0] rsp_aim_y,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int WQ_W  = FRAME_W + COORD_FRAC_BITS;
   localparam int S_W   = (WQ_W + 8 > 25) ? WQ_W + 8 : 25;
   localparam int ZQ_W  = (ZOOM_W > ZOOM_FRAC_BITS + 1) ? ZOOM_W : ZOOM_FRAC_BITS + 1;
   localparam int DEN_W = ZQ_W + 4;
   localparam int NUM_W = S_W - 1 + ZOOM_FRAC_BITS;
   localparam int LAT   = NUM_W + 4;

   localparam logic signed [S_W:0] SUM_MAX = (S_W+1)'(AIM_MAX);
   localparam logic signed [S_W:0] SUM_MIN = (S_W+1)'(AIM_MIN);

   function automatic logic [AIM_W-1:0] sat_aim(input logic signed [S_W:0] v);
      logic [AIM_W-1:0] r;
      if (v > SUM_MAX) begin
         r = SUM_MAX[AIM_W-1:0];
      end else if (v < SUM_MIN) begin
         r = SUM_MIN[AIM_W-1:0];
      end else begin
         r = v[AIM_W-1:0];
      end
      return r;
   endfunction

   logic [FRAME_W-1:0] frame_width_ff, frame_width_in;
   logic [FRAME_W-1:0] frame_height_ff, frame_height_in;
   logic cfg_write;
   logic [WQ_W-1:0] wq, hq;
   logic signed [S_W:0] cx, cy;

   gap_ctl_type band_ctl, div_ctl;
   logic [NUM_W-1:0] band_num_x, band_num_y, quo_x, quo_y;
   logic [DEN_W-1:0] band_den;

   logic signed [S_W:0] q_x, q_y;
   logic rsp_valid_ff;
   logic [AIM_W-1:0] aim_x_ff, aim_x_in, aim_y_ff, aim_y_in;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign cfg_write = psel & penable & pwrite;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (cfg_write) begin
         unique case (paddr[2])
            REG_FRAME_WIDTH:  frame_width_in  = pwdata[FRAME_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = pwdata[FRAME_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_FRAME_WIDTH:  prdata = 32'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = 32'(frame_height_ff);
      endcase
   end

   assign wq = {frame_width_ff, {COORD_FRAC_BITS{1'b0}}};
   assign hq = {frame_height_ff, {COORD_FRAC_BITS{1'b0}}};
   assign cx = $signed({{(S_W+2-WQ_W){1'b0}}, wq[WQ_W-1:1]});
   assign cy = $signed({{(S_W+2-WQ_W){1'b0}}, hq[WQ_W-1:1]});

   gap_band #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .ZOOM_FRAC_BITS (ZOOM_FRAC_BITS)
   ) u_band (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start & ~busy),
      .target_valid(req_target_valid),
      .box_x       (req_box_x),
      .box_y       (req_box_y),
      .box_width   (req_box_width),
      .box_height  (req_box_height),
      .zoom        (req_zoom),
      .wq          (wq),
      .hq          (hq),
      .out_ctl     (band_ctl),
      .out_num_x   (band_num_x),
      .out_num_y   (band_num_y),
      .out_den     (band_den)
   );

   gap_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (band_ctl),
      .in_num_x (band_num_x),
      .in_num_y (band_num_y),
      .in_den   (band_den),
      .out_ctl  (div_ctl),
      .out_quo_x(quo_x),
      .out_quo_y(quo_y)
   );

   always_comb begin
      q_x = $signed({2'b00, quo_x[S_W-2:0]});
      q_y = $signed({2'b00, quo_y[S_W-2:0]});
      if (div_ctl.neg_x) begin
         q_x = -q_x;
      end
      if (div_ctl.neg_y) begin
         q_y = -q_y;
      end
      aim_x_in = sat_aim(cx + q_x);
      aim_y_in = sat_aim(cy + q_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      aim_x_ff <= aim_x_in;
      aim_y_ff <= aim_y_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_aim_x = $signed(aim_x_ff);
   assign rsp_aim_y = $signed(aim_y_ff);

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid)
      else $error("accepted transfer produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !reset, LAT))
      else $error("result without an accepted transfer");

   a_lost_centre: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start && !reset && !req_target_valid, LAT)) |->
      (rsp_aim_x == $signed(sat_aim(cx)) && rsp_aim_y == $signed(sat_aim(cy))))
      else $error("lost target did not aim at the frame centre");

endmodule

// ===== tb/gimbal_aim_point_from_box_tb.sv =====
// Self-checking testbench for gimbal_aim_point_from_box: a directed table, then
// random boxes over several frame sizes. Needs gap_pkg and the block's RTL.
`timescale 1ns / 100ps

module gimbal_aim_point_from_box_tb import gap_pkg::*; ;

   localparam int COORD_FRAC     = 4;
   localparam int ZOOM_FRAC      = 8;
   localparam int ZOOM_ONE       = 1 << ZOOM_FRAC;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 125;
   localparam int TAIL_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic               valid;
      logic [BOX_W-1:0]   x;
      logic [BOX_W-1:0]   y;
      logic [BOX_W-1:0]   w;
      logic [BOX_W-1:0]   h;
      logic [ZOOM_W-1:0]  zoom;
   } box_type;

   typedef struct packed {
      logic signed [AIM_W-1:0] x;
      logic signed [AIM_W-1:0] y;
   } aim_type;

   typedef enum logic {ROW_BOX, ROW_FRAME} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      box_type      box;
      logic         typed;
      aim_type      aim;
      logic [31:0]  frame_w;
      logic [31:0]  frame_h;
   } stim_row_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_target_valid;
   logic [BOX_W-1:0]        req_box_x;
   logic [BOX_W-1:0]        req_box_y;
   logic [BOX_W-1:0]        req_box_width;
   logic [BOX_W-1:0]        req_box_height;
   logic [ZOOM_W-1:0]       req_zoom;
   logic                    rsp_valid;
   logic signed [AIM_W-1:0] rsp_aim_x;
   logic signed [AIM_W-1:0] rsp_aim_y;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [2:0]              paddr;
   logic [31:0]             pwdata;
   logic [31:0]             prdata;
   logic                    pready;

   logic [FRAME_W-1:0] frame_width_q;
   logic [FRAME_W-1:0] frame_height_q;
   aim_type            pending_aim[$];
   stim_row_type       directed_rows[$];
   aim_type            oldest_aim;
   int                 errors;
   int                 aims_checked;
   int                 boxes_sent;
   int                 settings_used;
   int                 quiet_cycles;

   gimbal_aim_point_from_box #(
      .COORD_FRAC_BITS(COORD_FRAC),
      .ZOOM_FRAC_BITS (ZOOM_FRAC)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_target_valid(req_target_valid),
      .req_box_x       (req_box_x),
      .req_box_y       (req_box_y),
      .req_box_width   (req_box_width),
      .req_box_height  (req_box_height),
      .req_zoom        (req_zoom),
      .rsp_valid       (rsp_valid),
      .rsp_aim_x       (rsp_aim_x),
      .rsp_aim_y       (rsp_aim_y),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [AIM_W-1:0] saturate_aim(longint v);
      if (v > AIM_MAX) return AIM_W'(AIM_MAX);
      if (v < AIM_MIN) return AIM_W'(AIM_MIN);
      return AIM_W'(v);
   endfunction

   function automatic logic signed [AIM_W-1:0] aim_about(longint centre, longint offset,
                                                         longint zq);
      longint quotient;
      quotient = (offset * (longint'(1) << ZOOM_FRAC)) / (zq * 10);
      return saturate_aim(centre + quotient);
   endfunction

   function automatic aim_type predict_aim(box_type b, logic [FRAME_W-1:0] fw,
                                           logic [FRAME_W-1:0] fh);
      longint  wq, hq, cx, cy, bx, by, bw, bh, zq, n, m;
      aim_type r;
      wq = longint'(fw) * (longint'(1) << COORD_FRAC);
      hq = longint'(fh) * (longint'(1) << COORD_FRAC);
      cx = wq / 2;
      cy = hq / 2;
      if (!b.valid) begin
         r.x = saturate_aim(cx);
         r.y = saturate_aim(cy);
         return r;
      end
      bx = longint'(b.x);
      by = longint'(b.y);
      bw = longint'(b.w);
      bh = longint'(b.h);
      zq = longint'(b.zoom);
      if (zq < ZOOM_ONE) zq = ZOOM_ONE;
      if (bx * 100 <= 15 * wq) n = -5 * wq;
      else if (bx * 100 >= 85 * wq) n = 5 * wq;
      else if (bx * 100 <= 30 * wq) n = 10 * bx - 5 * bw - 5 * wq;
      else if (bx * 100 >= 70 * wq) n = 10 * bx + 5 * bw - 5 * wq;
      else n = 10 * bx - 5 * wq;
      if (10 * (2 * by - bh) < 6 * hq) m = 20 * by - 5 * bh - 8 * hq;
      else m = 10 * by - bh - 5 * hq;
      r.x = aim_about(cx, n, zq);
      r.y = aim_about(cy, m, zq);
      return r;
   endfunction

   function automatic logic [BOX_W-1:0] clamp_coord(int v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return BOX_W'(v);
   endfunction

   function automatic box_type make_random_box(logic [FRAME_W-1:0] fw,
                                               logic [FRAME_W-1:0] fh);
      box_type b;
      int      wq, hq, pct, v;
      wq = int'(fw) << COORD_FRAC;
      hq = int'(fh) << COORD_FRAC;
      b.valid = ($urandom_range(0, 9) != 0);
      b.w = ($urandom_range(0, 1) == 1) ? BOX_W'($urandom) : BOX_W'($urandom_range(0, wq / 4));
      b.h = ($urandom_range(0, 1) == 1) ? BOX_W'($urandom) : BOX_W'($urandom_range(0, hq / 4));
      case ($urandom_range(0, 3))
         0: v = int'($urandom_range(0, 65535));
         1: v = int'($urandom_range(0, wq));
         default: begin
            case ($urandom_range(0, 3))
               0: pct = 15;
               1: pct = 30;
               2: pct = 70;
               default: pct = 85;
            endcase
            v = pct * wq / 100 + int'($urandom_range(0, 6)) - 3;
         end
      endcase
      b.x = clamp_coord(v);
      case ($urandom_range(0, 2))
         0: v = int'($urandom_range(0, 65535));
         1: v = int'($urandom_range(0, hq));
         default: v = (6 * hq / 10 + int'(b.h)) / 2 + int'($urandom_range(0, 4)) - 2;
      endcase
      b.y = clamp_coord(v);
      case ($urandom_range(0, 9))
         0: b.zoom = ZOOM_W'($urandom_range(0, ZOOM_ONE - 1));
         1: b.zoom = ZOOM_W'($urandom);
         default: b.zoom = ZOOM_W'($urandom_range(ZOOM_ONE, 4095));
      endcase
      return b;
   endfunction

   function automatic logic [31:0] make_random_frame();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = 32'd16;
         1: v = 32'd4096;
         2: v = $urandom_range(0, 8191);
         default: v = $urandom_range(16, 4096);
      endcase
      if ($urandom_range(0, 3) == 0) v[31:FRAME_W] = (32-FRAME_W)'($urandom);
      return v;
   endfunction

   function automatic void add_box(int valid, int x, int y, int w, int h, int zoom,
                                   int typed, int ax, int ay);
      stim_row_type r;
      r = '0;
      r.kind = ROW_BOX;
      r.box.valid = (valid != 0);
      r.box.x = BOX_W'(x);
      r.box.y = BOX_W'(y);
      r.box.w = BOX_W'(w);
      r.box.h = BOX_W'(h);
      r.box.zoom = ZOOM_W'(zoom);
      r.typed = (typed != 0);
      r.aim.x = AIM_W'(ax);
      r.aim.y = AIM_W'(ay);
      directed_rows = {directed_rows, r};
   endfunction

   function automatic void add_frame(int fw, int fh);
      stim_row_type r;
      r = '0;
      r.kind = ROW_FRAME;
      r.frame_w = fw;
      r.frame_h = fh;
      directed_rows = {directed_rows, r};
   endfunction

   task automatic csr_write(input logic reg_code, input logic [31:0] data);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {reg_code, 2'b00};
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (reg_code == REG_FRAME_WIDTH) frame_width_q = data[FRAME_W-1:0];
      else frame_height_q = data[FRAME_W-1:0];
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic csr_read_check(input logic reg_code);
      logic [31:0] want;
      want = (reg_code == REG_FRAME_WIDTH) ? 32'(frame_width_q) : 32'(frame_height_q);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = {reg_code, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) begin
         errors++;
         $display("%0t: register %0d read: expected %0d, actual %0d",
                  $time, reg_code, want, prdata);
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_frame(input logic [31:0] fw, input logic [31:0] fh);
      csr_write(REG_FRAME_WIDTH, fw);
      csr_write(REG_FRAME_HEIGHT, fh);
      csr_read_check(REG_FRAME_WIDTH);
      csr_read_check(REG_FRAME_HEIGHT);
      settings_used++;
   endtask

   task automatic drain_aims();
      @(negedge clock);
      start = 1'b0;
      while (pending_aim.size() != 0) @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_box(input box_type b, input logic typed, input aim_type typed_aim);
      aim_type want;
      want = typed ? typed_aim : predict_aim(b, frame_width_q, frame_height_q);
      @(negedge clock);
      start = 1'b1;
      req_target_valid = b.valid;
      req_box_x = b.x;
      req_box_y = b.y;
      req_box_width = b.w;
      req_box_height = b.h;
      req_zoom = b.zoom;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_aim = {pending_aim, want};
      boxes_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_aim.size() == 0) begin
            errors++;
            $display("%0t: unexpected aim point: expected none, actual x %0d y %0d",
                     $time, rsp_aim_x, rsp_aim_y);
         end else begin
            oldest_aim = pending_aim.pop_front();
            aims_checked++;
            if (rsp_aim_x !== oldest_aim.x) begin
               errors++;
               $display("%0t: aim_x: expected %0d, actual %0d",
                        $time, oldest_aim.x, rsp_aim_x);
            end
            if (rsp_aim_y !== oldest_aim.y) begin
               errors++;
               $display("%0t: aim_y: expected %0d, actual %0d",
                        $time, oldest_aim.y, rsp_aim_y);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      errors = 0;
      aims_checked = 0;
      boxes_sent = 0;
      settings_used = 1;
      quiet_cycles = 0;
      frame_width_q = FRAME_WIDTH_RESET;
      frame_height_q = FRAME_HEIGHT_RESET;
      reset = 1'b1;
      start = 1'b0;
      req_target_valid = 1'b0;
      req_box_x = '0;
      req_box_y = '0;
      req_box_width = '0;
      req_box_height = '0;
      req_zoom = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;

      add_box(0, 0, 0, 0, 0, 0, 1, 15360, 8640);
      add_box(0, 65535, 65535, 65535, 65535, 4095, 1, 15360, 8640);
      add_box(1, 0, 0, 0, 0, 256, 1, 0, -5184);
      add_box(1, 65535, 65535, 0, 0, 256, 1, 30720, 65535);
      add_box(1, 16000, 8640, 3200, 1600, 0, 0, 0, 0);
      add_box(1, 16000, 8640, 3200, 1600, 255, 0, 0, 0);
      add_box(1, 16000, 8640, 3200, 1600, 4095, 0, 0, 0);
      add_box(1, 4608, 9000, 3200, 1600, 512, 0, 0, 0);
      add_box(1, 4609, 9000, 3200, 1600, 512, 0, 0, 0);
      add_box(1, 9216, 9000, 3200, 1600, 300, 0, 0, 0);
      add_box(1, 9217, 9000, 3200, 1600, 300, 0, 0, 0);
      add_box(1, 21503, 9000, 3200, 1600, 700, 0, 0, 0);
      add_box(1, 21504, 9000, 3200, 1600, 700, 0, 0, 0);
      add_box(1, 26111, 9000, 3200, 1600, 1024, 0, 0, 0);
      add_box(1, 26112, 9000, 3200, 1600, 1024, 0, 0, 0);
      add_box(1, 12000, 5683, 2000, 1000, 256, 0, 0, 0);
      add_box(1, 12000, 5684, 2000, 1000, 256, 0, 0, 0);
      add_box(1, 6000, 4000, 65535, 65535, 2048, 0, 0, 0);
      add_frame(16, 16);
      add_box(0, 100, 100, 10, 10, 256, 1, 128, 128);
      add_box(1, 120, 90, 40, 30, 384, 0, 0, 0);
      add_frame(8191, 8191);
      add_box(0, 0, 0, 0, 0, 256, 1, 65528, 65528);
      add_box(1, 65535, 0, 65535, 65535, 256, 0, 0, 0);
      add_frame(0, 0);
      add_box(0, 500, 500, 0, 0, 256, 1, 0, 0);
      add_box(1, 0, 0, 0, 0, 256, 0, 0, 0);
      add_box(1, 400, 300, 50, 60, 512, 0, 0, 0);
      add_frame(4096, 4096);
      add_box(1, 30000, 20000, 800, 900, 256, 0, 0, 0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_read_check(REG_FRAME_WIDTH);
      csr_read_check(REG_FRAME_HEIGHT);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_FRAME) begin
            drain_aims();
            set_frame(directed_rows[i].frame_w, directed_rows[i].frame_h);
         end else begin
            send_box(directed_rows[i].box, directed_rows[i].typed, directed_rows[i].aim);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_aims();
         set_frame(make_random_frame(), make_random_frame());
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 2 && i == PHASE_ITEMS / 2) drain_aims();
            if (phase < PHASES - 1 && ((i / 20) % 3) != 2 && $urandom_range(0, 4) == 0)
               hold_off($urandom_range(1, 13));
            send_box(make_random_box(frame_width_q, frame_height_q), 1'b0, '0);
         end
      end

      drain_aims();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d boxes over %0d frame settings and checked %0d aim points.",
               boxes_sent, settings_used, aims_checked);
      $display("Errors found: %0d.", errors);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
